### design/fcms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcms_pkg
// Shared types and constants of the framebuffer configuration match scorer.
// ----------------------------------------------------------------------------
package fcms_pkg;

	localparam int NumLanes  = 8;
	localparam int CompWidth = 8;

	localparam logic signed [13:0] IdMatchScore   = 14'sd1000;
	localparam logic signed [13:0] IdMissScore    = -14'sd1000;
	localparam logic signed [10:0] PenaltyScore   = -11'sd1000;
	localparam logic signed [10:0] MaxCompScore   = 11'sd32;

	// colour lanes carry scale 4, the sample lane scale -1, the rest scale 1
	localparam logic [NumLanes-1:0] Scale4Lanes = 8'b0000_1111;
	localparam logic [NumLanes-1:0] InvertLanes = 8'b1000_0000;

	typedef enum logic [2:0] {
		REG_COLOR_WIDTHS = 3'd0,
		REG_DEPTH_BITS   = 3'd1,
		REG_STENCIL_BITS = 3'd2,
		REG_BUFFER_BITS  = 3'd3,
		REG_SAMPLE_COUNT = 3'd4,
		REG_CONFIG_ID    = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [31:0]       color_widths;
		logic signed [8:0] depth_bits;
		logic signed [8:0] stencil_bits;
		logic signed [8:0] buffer_bits;
		logic signed [8:0] sample_count;
		logic [15:0]       config_id;
	} cfg_t;

endpackage

### design/fcms_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcms_cfg_regs
// Target configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module fcms_cfg_regs import fcms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_widths <= 32'hFFFF_FFFF;
			cfg_q.depth_bits   <= -9'sd1;
			cfg_q.stencil_bits <= -9'sd1;
			cfg_q.buffer_bits  <= -9'sd1;
			cfg_q.sample_count <= -9'sd1;
			cfg_q.config_id    <= 16'd0;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_COLOR_WIDTHS: cfg_q.color_widths <= wr_data;
				REG_DEPTH_BITS:   cfg_q.depth_bits   <= wr_data[8:0];
				REG_STENCIL_BITS: cfg_q.stencil_bits <= wr_data[8:0];
				REG_BUFFER_BITS:  cfg_q.buffer_bits  <= wr_data[8:0];
				REG_SAMPLE_COUNT: cfg_q.sample_count <= wr_data[8:0];
				REG_CONFIG_ID:    cfg_q.config_id    <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/fcms_score_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcms_score_pipe
// Four-stage scoring pipeline: compare, component score, pair sum, total.
// ----------------------------------------------------------------------------
module fcms_score_pipe import fcms_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	input  logic [NumLanes-1:0][7:0] cand,
	input  logic [15:0]              cand_id,
	output logic                     out_valid,
	output logic signed [13:0]       out_score
);

	logic signed [8:0] tgt [NumLanes];

	// stage 1: differences and compare flags
	logic                    v_s1;
	logic signed [9:0]       diff_s1 [NumLanes];
	logic [NumLanes-1:0]     pen_s1, eq_s1, wide_s1, tneg_s1;
	logic                    id_use_s1, id_hit_s1;
	// stage 2: component scores
	logic                    v_s2;
	logic signed [10:0]      comp_s2 [NumLanes];
	logic                    id_use_s2, id_hit_s2;
	// stage 3: pair sums
	logic                    v_s3;
	logic signed [11:0]      pair_s3 [NumLanes/2];
	logic                    id_use_s3, id_hit_s3;
	// stage 4: total
	logic                    v_s4;
	logic signed [13:0]      score_s4;

	logic signed [10:0]      comp_d [NumLanes];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tgt[i] = {cfg.color_widths[8*i+7], cfg.color_widths[8*i +: 8]};
		end
		tgt[4] = cfg.depth_bits;
		tgt[5] = cfg.stencil_bits;
		tgt[6] = cfg.buffer_bits;
		tgt[7] = cfg.sample_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NumLanes; i++) begin
			diff_s1[i] <= $signed({2'b00, cand[i]}) - $signed({tgt[i][8], tgt[i]});
			pen_s1[i]  <= ((cand[i] != 8'd0) && (tgt[i] == 9'sd0)) ||
			              ((cand[i] == 8'd0) && (tgt[i] > 9'sd0));
			eq_s1[i]   <= ({1'b0, cand[i]} == tgt[i]);
			wide_s1[i] <= Scale4Lanes[i] && (cand[i] > 8'(CompWidth)) &&
			              (tgt[i] <= 9'(CompWidth));
			tneg_s1[i] <= tgt[i][8];
		end
		id_use_s1 <= (cfg.config_id != 16'd0);
		id_hit_s1 <= (cand_id == cfg.config_id);
	end

	always_comb begin
		logic signed [11:0] d;
		logic signed [12:0] r;
		for (int i = 0; i < NumLanes; i++) begin
			d = Scale4Lanes[i] ? {diff_s1[i], 2'b00} : {{2{diff_s1[i][9]}}, diff_s1[i]};
			if (InvertLanes[i] || tneg_s1[i])
				r = 13'sd32 - {d[11], d};
			else
				r = {d[11], d};
			if (r > 13'sd32)
				r = 13'sd32;
			if (r < 13'sd0)
				r = 13'sd0;
			if (pen_s1[i])
				comp_d[i] = PenaltyScore;
			else if (eq_s1[i])
				comp_d[i] = MaxCompScore;
			else if (wide_s1[i])
				comp_d[i] = PenaltyScore;
			else if (d <= 12'sd0)
				comp_d[i] = 11'sd0;
			else
				comp_d[i] = r[10:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NumLanes; i++) begin
			comp_s2[i] <= comp_d[i];
		end
		id_use_s2 <= id_use_s1;
		id_hit_s2 <= id_hit_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NumLanes/2; i++) begin
			pair_s3[i] <= 12'(comp_s2[2*i]) + 12'(comp_s2[2*i+1]);
		end
		id_use_s3 <= id_use_s2;
		id_hit_s3 <= id_hit_s2;
	end

	always_ff @(posedge clk) begin
		if (id_use_s3)
			score_s4 <= id_hit_s3 ? IdMatchScore : IdMissScore;
		else
			score_s4 <= 14'(pair_s3[0]) + 14'(pair_s3[1]) +
			            14'(pair_s3[2]) + 14'(pair_s3[3]);
	end

	assign out_valid = v_s4;
	assign out_score = score_s4;

endmodule

### design/framebuffer_config_match_scorer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_config_match_scorer_top
// Scores a candidate framebuffer configuration against a programmed target.
// ----------------------------------------------------------------------------
// Usage:
//   Program the target through wr_en / wr_index / wr_data while no candidate
//   is in flight. Present a candidate on the cand_* ports with start high;
//   busy never rises, so a candidate is taken at every edge with start high.
//   The score appears on match_score_value with done high for one cycle,
//   once its candidate has passed through every pipeline stage, in order.
// Throughput: one candidate per cycle, set by the four-stage pipeline
//   (compare, component score, pair sum, total).
// Reset: the target returns to "don't care" for every component with id
//   matching off, and any candidate in flight is dropped.
// The receiver cannot stall; it must take each result in its done cycle.
// ----------------------------------------------------------------------------
module framebuffer_config_match_scorer_top import fcms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         cand_red_bits,
	input  logic [7:0]         cand_green_bits,
	input  logic [7:0]         cand_blue_bits,
	input  logic [7:0]         cand_alpha_bits,
	input  logic [7:0]         cand_depth_bits,
	input  logic [7:0]         cand_stencil_bits,
	input  logic [7:0]         cand_buffer_bits,
	input  logic [7:0]         cand_sample_count,
	input  logic [15:0]        cand_config_id,
	output logic               done,
	output logic signed [13:0] match_score_value
);

	cfg_t                     cfg;
	logic [NumLanes-1:0][7:0] cand;

	assign busy = 1'b0;

	assign cand = {cand_sample_count, cand_buffer_bits, cand_stencil_bits,
	               cand_depth_bits, cand_alpha_bits, cand_blue_bits,
	               cand_green_bits, cand_red_bits};

	fcms_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	fcms_score_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (start && !busy),
		.cand      (cand),
		.cand_id   (cand_config_id),
		.out_valid (done),
		.out_score (match_score_value)
	);

endmodule

### tb/tb_framebuffer_config_match_scorer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framebuffer_config_match_scorer_top
// Self-checking bench for the framebuffer configuration match scorer.
// Programs target settings over the write port, sends candidates through the
// start/busy handshake and checks every score strobed on done against an
// in-bench scoring model, oldest first. Directed candidates cover the
// don't-care target after reset, every per-lane rule, id matching and the
// register decode; random traffic follows in phases of differing sender
// idling, each phase under several random targets.
// ----------------------------------------------------------------------------
module tb_framebuffer_config_match_scorer_top import fcms_pkg::*; ();

	localparam int ClkHalfPeriod = 2;
	localparam int ResetCycles   = 4;
	localparam int PipeLatency   = 4;
	localparam int DrainCycles   = PipeLatency + 4;
	localparam int CycleLimit    = 200000;
	localparam int MaxGap        = 50;
	localparam int MaxReported   = 10;
	localparam int NumTargetRegs = 6;
	localparam int ItemsPerSet   = 45;
	localparam int SetsPerPhase  = 3;

	localparam int ColourScale = 4;
	localparam int PlainScale  = 1;
	localparam int SampleScale = -1;
	localparam int LaneMax     = MaxCompScore;
	localparam int LanePenalty = PenaltyScore;

	typedef enum int {
		LANE_RED, LANE_GREEN, LANE_BLUE, LANE_ALPHA,
		LANE_DEPTH, LANE_STENCIL, LANE_BUFFER, LANE_SAMPLES
	} lane_t;

	typedef struct packed {
		logic [NumLanes-1:0][7:0] lanes;
		logic [15:0]              config_id;
	} cand_t;

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic [2:0]         wr_index;
	logic [31:0]        wr_data;
	logic               start;
	logic               busy;
	logic [7:0]         cand_red_bits;
	logic [7:0]         cand_green_bits;
	logic [7:0]         cand_blue_bits;
	logic [7:0]         cand_alpha_bits;
	logic [7:0]         cand_depth_bits;
	logic [7:0]         cand_stencil_bits;
	logic [7:0]         cand_buffer_bits;
	logic [7:0]         cand_sample_count;
	logic [15:0]        cand_config_id;
	logic               done;
	logic signed [13:0] match_score_value;

	cfg_t               target_model;
	logic signed [13:0] expected_scores[$];
	logic signed [13:0] wanted_score;
	int                 failures;
	int                 cycle_count;
	int                 sender_idle_pct;

	framebuffer_config_match_scorer_top i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.wr_en             (wr_en),
		.wr_index          (wr_index),
		.wr_data           (wr_data),
		.start             (start),
		.busy              (busy),
		.cand_red_bits     (cand_red_bits),
		.cand_green_bits   (cand_green_bits),
		.cand_blue_bits    (cand_blue_bits),
		.cand_alpha_bits   (cand_alpha_bits),
		.cand_depth_bits   (cand_depth_bits),
		.cand_stencil_bits (cand_stencil_bits),
		.cand_buffer_bits  (cand_buffer_bits),
		.cand_sample_count (cand_sample_count),
		.cand_config_id    (cand_config_id),
		.done              (done),
		.match_score_value (match_score_value)
	);

	always #(ClkHalfPeriod) clk = ~clk;

	// ------------------------------------------------------------------
	// Scoring model
	// ------------------------------------------------------------------
	function automatic int lane_target(cfg_t tgt, int lane);
		case (lane)
			LANE_DEPTH:   return int'(tgt.depth_bits);
			LANE_STENCIL: return int'(tgt.stencil_bits);
			LANE_BUFFER:  return int'(tgt.buffer_bits);
			LANE_SAMPLES: return int'(tgt.sample_count);
			default:      return int'($signed(tgt.color_widths[8*lane +: 8]));
		endcase
	endfunction

	function automatic int lane_score(int c, int t, int s);
		int d;
		int r;
		if ((c > 0 && t == 0) || (c == 0 && t > 0))
			return LanePenalty;
		if (c == t)
			return LaneMax;
		// wide colour channel that was never asked for
		if (c > CompWidth && t <= CompWidth && s > 1)
			return LanePenalty;
		d = (s < 0 ? -s : s) * (c - t);
		if (d <= 0)
			return 0;
		r = (s < 0 || t < 0) ? LaneMax - d : d;
		if (r > LaneMax)
			r = LaneMax;
		if (r < 0)
			r = 0;
		return r;
	endfunction

	function automatic logic signed [13:0] predict_score(cfg_t tgt, cand_t cand);
		int total;
		int scale;
		if (tgt.config_id != '0)
			return (cand.config_id == tgt.config_id) ? IdMatchScore : IdMissScore;
		total = 0;
		for (int i = 0; i < NumLanes; i++) begin
			scale = Scale4Lanes[i] ? ColourScale : (InvertLanes[i] ? SampleScale : PlainScale);
			total += lane_score(int'(cand.lanes[i]), lane_target(tgt, i), scale);
		end
		return total[13:0];
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic cand_t make_candidate(int r, int g, int b, int a, int dp, int st,
			int bf, int ns, logic [15:0] id);
		cand_t c;
		c.lanes[LANE_RED]     = 8'(r);
		c.lanes[LANE_GREEN]   = 8'(g);
		c.lanes[LANE_BLUE]    = 8'(b);
		c.lanes[LANE_ALPHA]   = 8'(a);
		c.lanes[LANE_DEPTH]   = 8'(dp);
		c.lanes[LANE_STENCIL] = 8'(st);
		c.lanes[LANE_BUFFER]  = 8'(bf);
		c.lanes[LANE_SAMPLES] = 8'(ns);
		c.config_id           = id;
		return c;
	endfunction

	function automatic logic [8:0] random_target_bits();
		case ($urandom_range(4))
			0:       return '1;
			1:       return '0;
			2, 3:    return 9'($urandom_range(1, 32));
			default: return 9'($urandom());
		endcase
	endfunction

	function automatic cfg_t random_target();
		cfg_t tgt;
		logic [8:0] bits;
		for (int i = 0; i < 4; i++) begin
			bits = random_target_bits();
			tgt.color_widths[8*i +: 8] = bits[7:0];
		end
		tgt.depth_bits   = random_target_bits();
		tgt.stencil_bits = random_target_bits();
		tgt.buffer_bits  = random_target_bits();
		tgt.sample_count = random_target_bits();
		tgt.config_id    = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535)) : '0;
		return tgt;
	endfunction

	// near the target in half the draws, so exact, small and clamped differences all occur
	function automatic cand_t random_candidate(cfg_t tgt);
		cand_t c;
		int t;
		int v;
		for (int i = 0; i < NumLanes; i++) begin
			t = lane_target(tgt, i);
			case ($urandom_range(5))
				0:       v = $urandom_range(255);
				1:       v = 0;
				2:       v = $urandom_range(16);
				default: v = (t < 0 ? 0 : t) + $urandom_range(6) - 3;
			endcase
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			c.lanes[i] = 8'(v);
		end
		if (tgt.config_id != '0 && $urandom_range(1) == 1)
			c.config_id = tgt.config_id;
		else
			c.config_id = 16'($urandom());
		return c;
	endfunction

	task automatic send_candidate(cand_t cand);
		int gap;
		gap = 0;
		start             <= 1'b1;
		cand_red_bits     <= cand.lanes[LANE_RED];
		cand_green_bits   <= cand.lanes[LANE_GREEN];
		cand_blue_bits    <= cand.lanes[LANE_BLUE];
		cand_alpha_bits   <= cand.lanes[LANE_ALPHA];
		cand_depth_bits   <= cand.lanes[LANE_DEPTH];
		cand_stencil_bits <= cand.lanes[LANE_STENCIL];
		cand_buffer_bits  <= cand.lanes[LANE_BUFFER];
		cand_sample_count <= cand.lanes[LANE_SAMPLES];
		cand_config_id    <= cand.config_id;
		do @(posedge clk); while (busy);
		expected_scores.push_back(predict_score(target_model, cand));
		while ($urandom_range(99) < sender_idle_pct && gap < MaxGap)
			gap++;
		// hold start high across back-to-back transfers
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_scores();
		if (start)
			start <= 1'b0;
		while (expected_scores.size() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] index, logic [31:0] data);
		wr_en    <= 1'b1;
		wr_index <= index;
		wr_data  <= data;
		@(posedge clk);
	endtask

	// junk above each register's width must be dropped by the block
	task automatic program_target(cfg_t tgt);
		logic [31:0] word;
		drain_scores();
		write_reg(REG_COLOR_WIDTHS, tgt.color_widths);
		word = $urandom();
		word[8:0] = tgt.depth_bits;
		write_reg(REG_DEPTH_BITS, word);
		word = $urandom();
		word[8:0] = tgt.stencil_bits;
		write_reg(REG_STENCIL_BITS, word);
		word = $urandom();
		word[8:0] = tgt.buffer_bits;
		write_reg(REG_BUFFER_BITS, word);
		word = $urandom();
		word[8:0] = tgt.sample_count;
		write_reg(REG_SAMPLE_COUNT, word);
		word = $urandom();
		word[15:0] = tgt.config_id;
		write_reg(REG_CONFIG_ID, word);
		wr_en <= 1'b0;
		target_model = tgt;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_dont_care_target();
		sender_idle_pct = 0;
		send_candidate(make_candidate(0, 0, 0, 0, 0, 0, 0, 0, 16'h0000));
		send_candidate(make_candidate(255, 255, 255, 255, 255, 255, 255, 255, 16'hFFFF));
		send_candidate(make_candidate(8, 8, 8, 8, 8, 8, 8, 8, 16'h1234));
		send_candidate(make_candidate(9, 0, 1, 8, 24, 8, 32, 4, 16'h0001));
	endtask

	task automatic test_lane_rules();
		sender_idle_pct = 18;
		program_target('{color_widths: {8'd0, 8'd8, 8'd8, 8'd8}, depth_bits: 9'sd24,
			stencil_bits: 9'sd0, buffer_bits: 9'sd32, sample_count: 9'sd4, config_id: 16'h0});
		// exact match on every lane
		send_candidate(make_candidate(8, 8, 8, 0, 24, 0, 32, 4, 16'h0));
		// present against zero target, absent against positive target
		send_candidate(make_candidate(0, 8, 8, 5, 0, 3, 32, 4, 16'h0));
		// colour wider than requested
		send_candidate(make_candidate(9, 255, 8, 0, 24, 0, 32, 4, 16'h0));
		// shortfall scores nothing, surplus rewarded, samples inverted
		send_candidate(make_candidate(7, 6, 1, 0, 25, 0, 40, 8, 16'h0));
		send_candidate(make_candidate(8, 8, 8, 0, 23, 0, 31, 2, 16'h0));
		// clamp at both ends
		send_candidate(make_candidate(8, 8, 8, 0, 255, 0, 255, 255, 16'h0));
		program_target('{color_widths: {8'sd16, -8'sd1, -8'sd128, 8'sd127},
			depth_bits: 9'sd255, stencil_bits: -9'sd256, buffer_bits: -9'sd2,
			sample_count: 9'sd0, config_id: 16'h0});
		send_candidate(make_candidate(255, 255, 255, 255, 255, 255, 255, 255, 16'hFFFF));
		send_candidate(make_candidate(0, 0, 0, 0, 0, 0, 0, 0, 16'h0));
		send_candidate(make_candidate(127, 200, 3, 20, 254, 1, 5, 0, 16'h0));
	endtask

	task automatic test_id_match();
		sender_idle_pct = 73;
		program_target('{color_widths: 32'h0, depth_bits: 9'sd0, stencil_bits: 9'sd0,
			buffer_bits: 9'sd0, sample_count: 9'sd0, config_id: 16'hFFFF});
		send_candidate(make_candidate(0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
		send_candidate(make_candidate(255, 255, 255, 255, 255, 255, 255, 255, 16'h0000));
		send_candidate(make_candidate(8, 8, 8, 8, 24, 8, 32, 4, 16'hFFFE));
		program_target('{color_widths: 32'hFFFF_FFFF, depth_bits: -9'sd1,
			stencil_bits: -9'sd1, buffer_bits: -9'sd1, sample_count: -9'sd1,
			config_id: 16'h0001});
		send_candidate(make_candidate(1, 2, 3, 4, 5, 6, 7, 8, 16'h0001));
		send_candidate(make_candidate(1, 2, 3, 4, 5, 6, 7, 8, 16'h8001));
	endtask

	task automatic test_register_decode();
		sender_idle_pct = 0;
		drain_scores();
		// unused indexes must leave the target untouched
		write_reg(3'(NumTargetRegs), $urandom());
		write_reg(3'(NumTargetRegs + 1), $urandom());
		wr_en <= 1'b0;
		send_candidate(make_candidate(1, 0, 0, 0, 0, 0, 0, 0, 16'h0001));
		send_candidate(make_candidate(0, 0, 0, 0, 0, 0, 0, 0, 16'h0002));
	endtask

	task automatic test_random_traffic();
		int idle_phases[3];
		idle_phases = '{0, 73, 18};
		foreach (idle_phases[p]) begin
			sender_idle_pct = idle_phases[p];
			for (int s = 0; s < SetsPerPhase; s++) begin
				program_target(random_target());
				for (int n = 0; n < ItemsPerSet; n++) begin
					if (n == ItemsPerSet / 2 && s == 1)
						drain_scores();
					send_candidate(random_candidate(target_model));
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Score checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_scores.size() == 0) begin
				failures++;
				if (failures <= MaxReported)
					$display("score %0d strobed with no candidate pending", match_score_value);
			end else begin
				wanted_score = expected_scores.pop_front();
				if (match_score_value !== wanted_score) begin
					failures++;
					if (failures <= MaxReported)
						$display("score mismatch: expected %0d, got %0d",
							wanted_score, match_score_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		failures          = 0;
		cycle_count       = 0;
		sender_idle_pct   = 0;
		wr_en             <= 1'b0;
		wr_index          <= '0;
		wr_data           <= '0;
		start             <= 1'b0;
		cand_red_bits     <= '0;
		cand_green_bits   <= '0;
		cand_blue_bits    <= '0;
		cand_alpha_bits   <= '0;
		cand_depth_bits   <= '0;
		cand_stencil_bits <= '0;
		cand_buffer_bits  <= '0;
		cand_sample_count <= '0;
		cand_config_id    <= '0;
		target_model = '{color_widths: 32'hFFFF_FFFF, depth_bits: -9'sd1,
			stencil_bits: -9'sd1, buffer_bits: -9'sd1, sample_count: -9'sd1,
			config_id: 16'h0};
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_dont_care_target();
		test_lane_rules();
		test_id_match();
		test_register_decode();
		test_random_traffic();

		drain_scores();
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
